// File: src/i2cras_pkg.sv
// i2cras_pkg: types and codes shared by the i2c register access sequencer
`timescale 1ns / 1ps
`default_nettype none

package i2cras_pkg;

   localparam int MAX_READ_BYTES = 16;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   // engine status codes, low three bits masked
   localparam logic [7:0] ST_START       = 8'h08;
   localparam logic [7:0] ST_RSTART      = 8'h10;
   localparam logic [7:0] ST_SLAW_ACK    = 8'h18;
   localparam logic [7:0] ST_DATA_TX_ACK = 8'h28;
   localparam logic [7:0] ST_ARB_LOST    = 8'h38;
   localparam logic [7:0] ST_SLAR_ACK    = 8'h40;
   localparam logic [7:0] ST_DATA_RX_ACK = 8'h50;
   localparam logic [7:0] ST_DATA_RX_NAK = 8'h58;
   localparam logic [7:0] STATUS_MASK    = 8'hF8;
   localparam logic [7:0] TIMEOUT_TAG    = 8'hFF;
   localparam logic       ADDR_BIT_READ  = 1'b1;
   localparam logic       ADDR_BIT_WRITE = 1'b0;

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_READ   = 2'd1,
      CMD_STATUS = 2'd2,
      CMD_TICK   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_START   = 3'd1,
      ACT_SEND    = 3'd2,
      ACT_RX_ACK  = 3'd3,
      ACT_RX_NAK  = 3'd4,
      ACT_STOP    = 3'd5,
      ACT_RELEASE = 3'd6
   } action_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [6:0]  slave_addr;
      logic [7:0]  reg_addr;
      logic [7:0]  write_value;
      logic [4:0]  read_count;
      logic [7:0]  bus_status;
      logic [7:0]  rx_data;
   } req_type;

   typedef struct packed {
      action_type  bus_action;
      logic [7:0]  tx_byte;
      logic        rx_valid;
      logic [7:0]  rx_byte;
      logic [3:0]  rx_index;
      logic        done_res;
      logic [15:0] error_code;
   } rsp_type;

endpackage

`default_nettype wire

// File: src/i2cras_if.sv
// i2cras_req_if and i2cras_rsp_if: valid/ready channels of the sequencer
`timescale 1ns / 1ps
`default_nettype none

interface i2cras_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [6:0] slave_addr;
   logic [7:0] reg_addr;
   logic [7:0] write_value;
   logic [4:0] read_count;
   logic [7:0] bus_status;
   logic [7:0] rx_data;

   modport source (
      output valid, cmd, slave_addr, reg_addr, write_value, read_count, bus_status, rx_data,
      input  ready
   );
   modport sink (
      input  valid, cmd, slave_addr, reg_addr, write_value, read_count, bus_status, rx_data,
      output ready
   );
endinterface

interface i2cras_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  bus_action;
   logic [7:0]  tx_byte;
   logic        rx_valid;
   logic [7:0]  rx_byte;
   logic [3:0]  rx_index;
   logic        done_res;
   logic [15:0] error_code;

   modport source (
      output valid, bus_action, tx_byte, rx_valid, rx_byte, rx_index, done_res, error_code,
      input  ready
   );
   modport sink (
      input  valid, bus_action, tx_byte, rx_valid, rx_byte, rx_index, done_res, error_code,
      output ready
   );
endinterface

`default_nettype wire

// File: src/i2c_register_access_sequencer_top.sv
// i2c_register_access_sequencer_top: request/status channels, output register, csr
//
//  channel | dir | handshake     | carries
//  req_ch  | in  | valid/ready   | request, engine status event or tick
//  rsp_ch  | out | valid/ready   | next bus action, read byte, done and error code
//  csr     | in  | csr_wr_en     | timeout_ticks, no read-back
//
// one item per cycle while req_ch.ready is high; its result is registered into the output register on accept.
// req_ch.ready stays high while the output register is empty or being taken this cycle,
// so a stall on rsp_ch holds back req_ch only once a result is waiting.
// reset (synchronous) returns the sequencer to idle and timeout_ticks to 1000.
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_access_sequencer_top
   import i2cras_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   i2cras_req_if.sink       req_ch,
   i2cras_rsp_if.source     rsp_ch,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   logic [15:0] timeout_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   req_type     item;
   rsp_type     res;
   logic        res_emit;
   logic        req_fire;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign item.cmd         = cmd_type'(req_ch.cmd);
   assign item.slave_addr  = req_ch.slave_addr;
   assign item.reg_addr    = req_ch.reg_addr;
   assign item.write_value = req_ch.write_value;
   assign item.read_count  = req_ch.read_count;
   assign item.bus_status  = req_ch.bus_status;
   assign item.rx_data     = req_ch.rx_data;

   i2cras_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .item_fire     (req_fire),
      .item          (item),
      .timeout_ticks (timeout_ff),
      .res_emit      (res_emit),
      .res           (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         if (req_fire) begin
            rsp_valid_ff <= res_emit;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload register, loaded only when an item produces a result
   always_ff @(posedge clock) begin
      if (req_fire && res_emit) begin
         rsp_ff <= res;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.bus_action = rsp_ff.bus_action;
   assign rsp_ch.tx_byte    = rsp_ff.tx_byte;
   assign rsp_ch.rx_valid   = rsp_ff.rx_valid;
   assign rsp_ch.rx_byte    = rsp_ff.rx_byte;
   assign rsp_ch.rx_index   = rsp_ff.rx_index;
   assign rsp_ch.done_res   = rsp_ff.done_res;
   assign rsp_ch.error_code = rsp_ff.error_code;

endmodule

`default_nettype wire

// File: src/i2cras_seq.sv
// i2cras_seq: transaction state machine, next bus action per item that yields a result
`timescale 1ns / 1ps
`default_nettype none

module i2cras_seq
   import i2cras_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        item_fire,
   input  wire req_type     item,
   input  wire logic [15:0] timeout_ticks,
   output      logic        res_emit,
   output      rsp_type     res
);

   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_START  = 4'd1,
      PH_SLAW   = 4'd2,
      PH_REG    = 4'd3,
      PH_VAL    = 4'd4,
      PH_RSTART = 4'd5,
      PH_SLAR   = 4'd6,
      PH_ACK    = 4'd7,
      PH_NAK    = 4'd8
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  expected_ff, expected_in;
   logic [15:0] ticks_ff, ticks_in;
   logic [6:0]  target_ff, target_in;
   logic [7:0]  register_ff, register_in;
   logic [7:0]  wdata_ff, wdata_in;
   logic [4:0]  bytes_left_ff, bytes_left_in;
   logic [3:0]  position_ff, position_in;
   logic        read_mode_ff, read_mode_in;

   logic [7:0]  got;
   logic [4:0]  count_min;
   logic [4:0]  count_sat;
   logic [4:0]  recv_left;
   logic        is_read;

   always_comb begin
      phase_in      = phase_ff;
      expected_in   = expected_ff;
      ticks_in      = ticks_ff;
      target_in     = target_ff;
      register_in   = register_ff;
      wdata_in      = wdata_ff;
      bytes_left_in = bytes_left_ff;
      position_in   = position_ff;
      read_mode_in  = read_mode_ff;
      res_emit      = 1'b0;
      res           = '0;
      got           = item.bus_status & STATUS_MASK;
      is_read       = (item.cmd == CMD_READ);
      count_min     = (item.read_count == 5'd0) ? 5'd1 : item.read_count;
      count_sat     = (count_min > 5'(MAX_READ_BYTES)) ? 5'(MAX_READ_BYTES) : count_min;
      recv_left     = bytes_left_ff;

      case (item.cmd)
         CMD_WRITE, CMD_READ: begin
            if (phase_ff == PH_IDLE) begin
               target_in      = item.slave_addr;
               register_in    = item.reg_addr;
               wdata_in       = item.write_value;
               read_mode_in   = is_read;
               bytes_left_in  = is_read ? count_sat : 5'd0;
               position_in    = 4'd0;
               phase_in       = PH_START;
               expected_in    = ST_START;
               ticks_in       = timeout_ticks;
               res_emit       = 1'b1;
               res.bus_action = ACT_START;
            end
         end
         CMD_TICK: begin
            if (phase_ff != PH_IDLE) begin
               if (ticks_ff <= 16'd1) begin
                  ticks_in       = 16'd0;
                  phase_in       = PH_IDLE;
                  res_emit       = 1'b1;
                  res.bus_action = ACT_STOP;
                  res.done_res   = 1'b1;
                  res.error_code = {TIMEOUT_TAG, expected_ff};
               end else begin
                  ticks_in = ticks_ff - 16'd1;
               end
            end
         end
         CMD_STATUS: begin
            if (phase_ff != PH_IDLE) begin
               res_emit = 1'b1;
               if (got != expected_ff) begin
                  phase_in       = PH_IDLE;
                  ticks_in       = 16'd0;
                  res.bus_action = (got == ST_ARB_LOST) ? ACT_RELEASE : ACT_STOP;
                  res.done_res   = 1'b1;
                  res.error_code = {got, expected_ff};
               end else begin
                  ticks_in = timeout_ticks;
                  case (phase_ff)
                     PH_START: begin
                        phase_in       = PH_SLAW;
                        expected_in    = ST_SLAW_ACK;
                        res.bus_action = ACT_SEND;
                        res.tx_byte    = {target_ff, ADDR_BIT_WRITE};
                     end
                     PH_SLAW: begin
                        phase_in       = PH_REG;
                        expected_in    = ST_DATA_TX_ACK;
                        res.bus_action = ACT_SEND;
                        res.tx_byte    = register_ff;
                     end
                     PH_REG: begin
                        if (read_mode_ff) begin
                           phase_in       = PH_RSTART;
                           expected_in    = ST_RSTART;
                           res.bus_action = ACT_START;
                        end else begin
                           phase_in       = PH_VAL;
                           expected_in    = ST_DATA_TX_ACK;
                           res.bus_action = ACT_SEND;
                           res.tx_byte    = wdata_ff;
                        end
                     end
                     PH_VAL: begin
                        phase_in       = PH_IDLE;
                        ticks_in       = 16'd0;
                        res.bus_action = ACT_STOP;
                        res.done_res   = 1'b1;
                     end
                     PH_RSTART: begin
                        phase_in       = PH_SLAR;
                        expected_in    = ST_SLAR_ACK;
                        res.bus_action = ACT_SEND;
                        res.tx_byte    = {target_ff, ADDR_BIT_READ};
                     end
                     PH_SLAR, PH_ACK: begin
                        if (phase_ff == PH_ACK) begin
                           // deliver the byte, then ask for the next one
                           res.rx_valid = 1'b1;
                           res.rx_byte  = item.rx_data;
                           res.rx_index = position_ff;
                           position_in  = position_ff + 4'd1;
                           if (bytes_left_ff != 5'd0) begin
                              recv_left = bytes_left_ff - 5'd1;
                           end
                           bytes_left_in = recv_left;
                        end
                        if (recv_left > 5'd1) begin
                           phase_in       = PH_ACK;
                           expected_in    = ST_DATA_RX_ACK;
                           res.bus_action = ACT_RX_ACK;
                        end else begin
                           phase_in       = PH_NAK;
                           expected_in    = ST_DATA_RX_NAK;
                           res.bus_action = ACT_RX_NAK;
                        end
                     end
                     PH_NAK: begin
                        res.rx_valid   = 1'b1;
                        res.rx_byte    = item.rx_data;
                        res.rx_index   = position_ff;
                        position_in    = position_ff + 4'd1;
                        bytes_left_in  = 5'd0;
                        phase_in       = PH_IDLE;
                        ticks_in       = 16'd0;
                        res.bus_action = ACT_STOP;
                        res.done_res   = 1'b1;
                     end
                     default: begin
                        res_emit = 1'b0;
                     end
                  endcase
               end
            end
         end
         default: begin
            res_emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         expected_ff   <= 8'h00;
         ticks_ff      <= 16'd0;
         target_ff     <= 7'd0;
         register_ff   <= 8'h00;
         wdata_ff      <= 8'h00;
         bytes_left_ff <= 5'd0;
         position_ff   <= 4'd0;
         read_mode_ff  <= 1'b0;
      end else if (item_fire) begin
         phase_ff      <= phase_in;
         expected_ff   <= expected_in;
         ticks_ff      <= ticks_in;
         target_ff     <= target_in;
         register_ff   <= register_in;
         wdata_ff      <= wdata_in;
         bytes_left_ff <= bytes_left_in;
         position_ff   <= position_in;
         read_mode_ff  <= read_mode_in;
      end
   end

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      item_fire && res_emit && res.done_res |=> phase_ff == PH_IDLE)
      else $error("transaction end did not return to idle");

   a_rx_only_when_receiving: assert property (@(posedge clock) disable iff (reset)
      item_fire && res_emit && res.rx_valid |-> phase_ff == PH_ACK || phase_ff == PH_NAK)
      else $error("read byte delivered outside a receive step");

   a_busy_has_expected: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> expected_ff != 8'h00)
      else $error("busy without an expected status");

   a_bytes_left_bound: assert property (@(posedge clock) disable iff (reset)
      bytes_left_ff <= 5'(MAX_READ_BYTES))
      else $error("remaining byte count above limit");

   a_ack_needs_more: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ACK |-> bytes_left_ff > 5'd1)
      else $error("ack step with one or no byte left");

endmodule

`default_nettype wire
